[src/lse_pkg.sv]
package lse_pkg;

    localparam int LENGTH_BITS = 24;
    localparam int BYTE_BITS   = 8;
    localparam int BYTE_SHIFT  = 3;
    localparam int PROC_W      = LENGTH_BITS + BYTE_SHIFT;
    localparam int BUF_W       = 15;
    localparam int CNT_W       = 4;
    localparam int BPB_W       = 4;
    localparam int CFG_W       = LENGTH_BITS;
    localparam int CFG_IDX_W   = 2;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_MODE          = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_BYTE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_BYTES = 2'd2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_UNDERRUN = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic {
        MODE_EMBED   = 1'b0,
        MODE_EXTRACT = 1'b1
    } mode_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_COVER   = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [BYTE_BITS-1:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0]  out_byte;
        logic                  finished;
        status_t               status;
    } result_t;

    typedef struct packed {
        mode_t                   mode;
        logic [BPB_W-1:0]        bits_per_byte;
        logic [LENGTH_BITS-1:0]  payload_bytes;
    } cfg_t;

endpackage

[src/lse_in_stage.sv]
module lse_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lse_pkg::item_t      s_item,
    input  logic                fire,
    output logic                item_valid,
    output lse_pkg::item_t      item
);

    logic           valid_reg;
    logic           valid_next;
    lse_pkg::item_t item_reg;

    // slot frees up when the held beat moves on this cycle
    assign s_ready    = !valid_reg || fire;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (fire ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[src/lse_core.sv]
module lse_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                clear,
    input  lse_pkg::cfg_t       cfg,
    input  lse_pkg::item_t      item,
    input  logic                fire,
    output logic                res_valid,
    output lse_pkg::result_t    res
);

    logic [lse_pkg::BUF_W-1:0]   buf_reg,  buf_next;
    logic [lse_pkg::CNT_W-1:0]   cnt_reg,  cnt_next;
    logic [lse_pkg::PROC_W-1:0]  proc_reg, proc_next;
    logic                        done_reg, done_next;

    logic [lse_pkg::PROC_W-1:0]  total;
    logic [lse_pkg::PROC_W:0]    diff;
    logic [lse_pkg::PROC_W-1:0]  left;
    logic                        is_done;
    logic [lse_pkg::CNT_W-1:0]   k;
    logic                        left_hi_zero;
    logic                        left_lt_k;
    logic                        left_le_k;
    logic [lse_pkg::CNT_W-1:0]   n;
    logic [lse_pkg::BYTE_BITS:0] mask9;
    logic [lse_pkg::BYTE_BITS-1:0] mask;
    logic [lse_pkg::PROC_W-1:0]  proc_sum;
    logic [lse_pkg::BUF_W-1:0]   xbuf_base, xbuf_new;
    logic [lse_pkg::CNT_W-1:0]   xcnt_base, xcnt_new;

    // remaining payload bits; a borrow or zero means the run is complete
    assign total   = {cfg.payload_bytes, lse_pkg::BYTE_SHIFT'(0)};
    assign diff    = {1'b0, total} - {1'b0, proc_reg};
    assign left    = diff[lse_pkg::PROC_W-1:0];
    assign is_done = done_reg || diff[lse_pkg::PROC_W] || (left == '0);

    // bits_per_byte clamped to 1..8
    always_comb begin
        if (cfg.bits_per_byte == '0) begin
            k = lse_pkg::CNT_W'(1);
        end else if (cfg.bits_per_byte > lse_pkg::CNT_W'(lse_pkg::BYTE_BITS)) begin
            k = lse_pkg::CNT_W'(lse_pkg::BYTE_BITS);
        end else begin
            k = cfg.bits_per_byte;
        end
    end

    assign left_hi_zero = (left[lse_pkg::PROC_W-1:lse_pkg::CNT_W] == '0);
    assign left_lt_k    = left_hi_zero && (left[lse_pkg::CNT_W-1:0] < k);
    assign left_le_k    = left_hi_zero && (left[lse_pkg::CNT_W-1:0] <= k);
    assign n            = left_lt_k ? left[lse_pkg::CNT_W-1:0] : k;
    assign mask9        = ((lse_pkg::BYTE_BITS+1)'(1) << n) - (lse_pkg::BYTE_BITS+1)'(1);
    assign mask         = mask9[lse_pkg::BYTE_BITS-1:0];
    assign proc_sum     = proc_reg + lse_pkg::PROC_W'(n);

    // extract path: stale full buffer is dropped before appending
    assign xbuf_base = cnt_reg[lse_pkg::CNT_W-1] ? '0 : buf_reg;
    assign xcnt_base = cnt_reg[lse_pkg::CNT_W-1] ? '0 : cnt_reg;
    assign xbuf_new  = xbuf_base | (lse_pkg::BUF_W'(item.data_byte & mask) << xcnt_base);
    assign xcnt_new  = xcnt_base + n;

    always_comb begin
        buf_next      = buf_reg;
        cnt_next      = cnt_reg;
        proc_next     = proc_reg;
        done_next     = done_reg;
        res_valid     = 1'b0;
        res.out_byte  = item.data_byte;
        res.finished  = 1'b0;
        res.status    = lse_pkg::ST_OK;
        if (item.kind == lse_pkg::KIND_PAYLOAD) begin
            if (cfg.mode == lse_pkg::MODE_EMBED) begin
                if (cnt_reg[lse_pkg::CNT_W-1]) begin
                    res_valid    = 1'b1;
                    res.out_byte = '0;
                    res.finished = is_done;
                    res.status   = lse_pkg::ST_OVERFLOW;
                end else begin
                    buf_next = buf_reg | (lse_pkg::BUF_W'(item.data_byte) << cnt_reg);
                    cnt_next = cnt_reg + lse_pkg::CNT_W'(lse_pkg::BYTE_BITS);
                end
            end
        end else if (is_done) begin
            done_next = 1'b1;
            if (cfg.mode == lse_pkg::MODE_EMBED) begin
                res_valid    = 1'b1;
                res.finished = 1'b1;
            end
        end else if (cfg.mode == lse_pkg::MODE_EMBED) begin
            res_valid = 1'b1;
            if (cnt_reg < n) begin
                res.status = lse_pkg::ST_UNDERRUN;
            end else begin
                res.out_byte = (item.data_byte & ~mask)
                             | (buf_reg[lse_pkg::BYTE_BITS-1:0] & mask);
                res.finished = done_reg || left_le_k;
                buf_next     = buf_reg >> n;
                cnt_next     = cnt_reg - n;
                proc_next    = proc_sum;
                done_next    = done_reg || left_le_k;
            end
        end else begin
            proc_next = proc_sum;
            done_next = done_reg || left_le_k;
            if (xcnt_new[lse_pkg::CNT_W-1]) begin
                res_valid    = 1'b1;
                res.out_byte = xbuf_new[lse_pkg::BYTE_BITS-1:0];
                res.finished = done_reg || left_le_k;
                buf_next     = xbuf_new >> lse_pkg::BYTE_BITS;
                cnt_next     = xcnt_new - lse_pkg::CNT_W'(lse_pkg::BYTE_BITS);
            end else begin
                buf_next = xbuf_new;
                cnt_next = xcnt_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            buf_reg  <= '0;
            cnt_reg  <= '0;
            proc_reg <= '0;
            done_reg <= 1'b0;
        end else if (fire) begin
            buf_reg  <= buf_next;
            cnt_reg  <= cnt_next;
            proc_reg <= proc_next;
            done_reg <= done_next;
        end
    end

endmodule

[src/lse_out_stage.sv]
module lse_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  lse_pkg::result_t    res,
    input  logic                m_ready,
    output logic                m_valid,
    output lse_pkg::result_t    m_res
);

    logic             valid_reg;
    logic             valid_next;
    lse_pkg::result_t res_reg;

    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

[src/lsb_stego_embed_extract.sv]
// LSB steganography embed/extract. Each beat on the s_ side is either a
// payload byte (tuser = 0, pushed into a 15-bit bit buffer in embed mode,
// ignored in extract mode) or a cover/stego byte (tuser = 1). In embed mode
// every cover byte produces one m_ beat: the byte with its low
// bits_per_byte bits (1..8, clamped) replaced by buffered payload bits, LSB
// first; once payload_bytes*8 bits are used, cover bytes pass unchanged with
// finished set. Too few buffered bits gives an unchanged byte with status
// underrun; a push into a buffer already holding 8+ bits is dropped and
// reported with status overflow. In extract mode, low bits are gathered and
// each completed payload byte is emitted. Rate: one beat per clock while
// the m_ side does not stall; an accepted beat passes the input register,
// then the result register, before m_tvalid rises; the loop through the bit
// buffer and processed-bit counter (one 27-bit subtract and compare) sets
// the clock. Write config only while idle; writing mode resets the stream.
module lsb_stego_embed_extract (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config write port
    input  logic                          cfg_we,
    input  logic [lse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lse_pkg::CFG_W-1:0]     cfg_data,
    // input beats
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  logic                          s_tuser,   // [0] kind
    // result beats
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] out_byte
    output logic [2:0]                    m_tuser    // [0] finished, [2:1] status
);

    lse_pkg::cfg_t    cfg_reg;
    lse_pkg::item_t   s_item;
    lse_pkg::item_t   item;
    lse_pkg::result_t res;
    lse_pkg::result_t m_res;
    logic             item_valid;
    logic             fire;
    logic             res_valid;
    logic             clear;

    // ---------------------------------------------------------------------
    // Config registers; a mode write also clears the stream state
    // ---------------------------------------------------------------------
    assign clear = cfg_we && (cfg_index == lse_pkg::REG_MODE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode          <= lse_pkg::MODE_EMBED;
            cfg_reg.bits_per_byte <= lse_pkg::BPB_W'(1);
            cfg_reg.payload_bytes <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                lse_pkg::REG_MODE: begin
                    cfg_reg.mode <= lse_pkg::mode_t'(cfg_data[0]);
                end
                lse_pkg::REG_BITS_PER_BYTE: begin
                    cfg_reg.bits_per_byte <= cfg_data[lse_pkg::BPB_W-1:0];
                end
                lse_pkg::REG_PAYLOAD_BYTES: begin
                    cfg_reg.payload_bytes <= cfg_data[lse_pkg::LENGTH_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------------
    assign s_item.kind      = lse_pkg::kind_t'(s_tuser);
    assign s_item.data_byte = s_tdata;

    // Held beat is processed once the output register is free or draining.
    // Beats with no result also wait here, which keeps ordering simple.
    assign fire = item_valid && (!m_tvalid || m_tready);

    lse_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .fire       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    // ---------------------------------------------------------------------
    // Bit buffer, counters and byte rewrite
    // ---------------------------------------------------------------------
    lse_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (clear),
        .cfg       (cfg_reg),
        .item      (item),
        .fire      (fire),
        .res_valid (res_valid),
        .res       (res)
    );

    // ---------------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------------
    lse_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (fire && res_valid),
        .res     (res),
        .m_ready (m_tready),
        .m_valid (m_tvalid),
        .m_res   (m_res)
    );

    assign m_tdata = m_res.out_byte;
    assign m_tuser = {m_res.status, m_res.finished};

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    // an underrun byte never claims the payload is complete
    a_underrun_not_finished: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[2:1] == lse_pkg::ST_UNDERRUN)) |-> !m_tuser[0])
        else $error("underrun result flagged finished");

    // a new result is never loaded over one that is still stalled
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !fire)
        else $error("result register overwritten while stalled");

    // an accepted beat is held in the input register on the next cycle
    a_accept_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> item_valid)
        else $error("accepted beat lost");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

// Block-level bench for the k-bit LSB stego embed/extract unit.
// A behavioral copy of the stream state (bit buffer, fill count, processed
// bit count, done flag) runs beside the DUT. Every accepted input beat is
// pushed through that copy, and any result it yields is queued. The result
// monitor pops the queue on each accepted m_ beat and compares field by field.
// The directed tests come first. Then random streams run in both modes with
// random backpressure on both sides, save for a steady embed opening stretch.

module tb;
    import lse_pkg::*;

    // ------------------------------------------------------------------
    // clock, reset, DUT I/O (all inputs start at known values)
    // ------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;
    logic [2:0]            m_tuser;

    always #4 aclk = ~aclk;

    lsb_stego_embed_extract dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [7:0] data_byte
        .s_tuser   (s_tuser),    // [0] kind
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [7:0] out_byte
        .m_tuser   (m_tuser)     // [0] finished, [2:1] status
    );

    // ------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------
    int      errors = 0;
    logic    steady = 1'b0;      // 1: no idle cycles on either side
    result_t stego_out_q[$];     // results still owed by the DUT

    // shadow copy of config and stream state
    mode_t        cur_mode  = MODE_EMBED;
    logic [3:0]   cur_bpb   = 4'd1;
    logic [23:0]  cur_len   = '0;
    logic [14:0]  pend_bits = '0;
    logic [3:0]   pend_cnt  = '0;
    logic [26:0]  done_bits = '0;
    logic         done_seen = 1'b0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [26:0] total_bits();
        return {cur_len, 3'b000};
    endfunction

    function automatic logic all_done();
        return done_seen || (done_bits >= total_bits());
    endfunction

    // payload bits carried by the next cover byte; bpb clamped to 1..8,
    // and capped by what is left of the payload
    function automatic logic [3:0] step_bits();
        logic [3:0]  k;
        logic [26:0] left;
        k = (cur_bpb == 4'd0) ? 4'd1 : (cur_bpb > 4'd8) ? 4'd8 : cur_bpb;
        left = total_bits() - done_bits;
        return (left < 27'(k)) ? left[3:0] : k;
    endfunction

    function automatic void queue_out(logic [7:0] b, logic fin, status_t st);
        result_t r;
        r.out_byte = b;
        r.finished = fin;
        r.status   = st;
        stego_out_q.push_back(r);
    endfunction

    task automatic stego_predict(input kind_t kind, input logic [7:0] d);
        logic [3:0] n;
        logic [8:0] lowm;
        logic [7:0] mask;
        logic [7:0] b;
        if (cur_mode == MODE_EMBED) begin
            if (kind == KIND_PAYLOAD) begin
                if (pend_cnt > 4'd7) begin
                    // buffer already holds a byte or more: push dropped
                    queue_out(8'h00, all_done(), ST_OVERFLOW);
                end else begin
                    pend_bits = pend_bits | (15'(d) << pend_cnt);
                    pend_cnt  = pend_cnt + 4'd8;
                end
            end else if (all_done()) begin
                done_seen = 1'b1;
                queue_out(d, 1'b1, ST_OK);
            end else begin
                n = step_bits();
                if (pend_cnt < n) begin
                    queue_out(d, 1'b0, ST_UNDERRUN);
                end else begin
                    lowm = (9'd1 << n) - 9'd1;
                    mask = lowm[7:0];
                    b = (d & ~mask) | (pend_bits[7:0] & mask);
                    pend_bits = pend_bits >> n;
                    pend_cnt  = pend_cnt - n;
                    done_bits = done_bits + 27'(n);
                    if (done_bits >= total_bits())
                        done_seen = 1'b1;
                    queue_out(b, done_seen, ST_OK);
                end
            end
        end else if (kind == KIND_COVER) begin
            // extract: payload pushes are dropped silently
            if (all_done()) begin
                done_seen = 1'b1;
            end else begin
                if (pend_cnt > 4'd7) begin
                    pend_bits = '0;
                    pend_cnt  = '0;
                end
                n = step_bits();
                lowm = (9'd1 << n) - 9'd1;
                mask = lowm[7:0];
                pend_bits = pend_bits | (15'(d & mask) << pend_cnt);
                pend_cnt  = pend_cnt + n;
                done_bits = done_bits + 27'(n);
                if (done_bits >= total_bits())
                    done_seen = 1'b1;
                if (pend_cnt >= 4'd8) begin
                    queue_out(pend_bits[7:0], done_seen, ST_OK);
                    pend_bits = pend_bits >> 8;
                    pend_cnt  = pend_cnt - 4'd8;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    // register write; DUT must be idle. Writing mode clears the stream.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MODE: begin
                cur_mode  = mode_t'(val[0]);
                pend_bits = '0;
                pend_cnt  = '0;
                done_bits = '0;
                done_seen = 1'b0;
            end
            REG_BITS_PER_BYTE: cur_bpb = val[3:0];
            REG_PAYLOAD_BYTES: cur_len = val[23:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // one input beat; valid stays high afterward so back-to-back beats
    // go out without a bubble
    task automatic send_beat(input kind_t k, input logic [7:0] d);
        while (!steady && $urandom_range(0, 99) < 36) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        stego_predict(k, d);
    endtask

    // stop sending, wait for every owed result, then let beats that give
    // no result clear the two-stage pipe
    task automatic settle();
        s_tvalid <= 1'b0;
        while (stego_out_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // sink side: random stalls unless in a steady stretch
    always @(posedge aclk)
        m_tready <= steady || ($urandom_range(0, 99) >= 36);

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (stego_out_q.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, actual byte %02h tuser %03b",
                         $time, m_tdata, m_tuser);
                errors++;
            end else begin
                want = stego_out_q.pop_front();
                if (m_tdata !== want.out_byte) begin
                    $display("%0t: out_byte mismatch: expected %02h actual %02h",
                             $time, want.out_byte, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== want.finished) begin
                    $display("%0t: finished mismatch: expected %0b actual %0b",
                             $time, want.finished, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[2:1] !== want.status) begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, m_tuser[2:1]);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // out of reset: embed, 1 bit/byte, zero length -> already finished
    task automatic test_reset_defaults();
        send_beat(KIND_COVER, 8'hA5);        // passes, finished
        send_beat(KIND_PAYLOAD, 8'hFF);      // fills buffer
        send_beat(KIND_PAYLOAD, 8'h00);      // buffer full -> overflow
        settle();
    endtask

    // underrun, normal embed, overflow, short last cover byte, passthrough
    task automatic test_embed_basic();
        write_reg(REG_MODE, CFG_W'(MODE_EMBED));
        write_reg(REG_BITS_PER_BYTE, 24'd3);
        write_reg(REG_PAYLOAD_BYTES, 24'd1);
        send_beat(KIND_COVER, 8'h00);        // nothing buffered: underrun
        send_beat(KIND_PAYLOAD, 8'hFF);
        send_beat(KIND_COVER, 8'h00);
        send_beat(KIND_COVER, 8'hFF);
        send_beat(KIND_PAYLOAD, 8'h00);
        send_beat(KIND_PAYLOAD, 8'h55);      // overflow
        send_beat(KIND_COVER, 8'h00);        // only 2 bits left to embed
        send_beat(KIND_COVER, 8'h3C);        // after payload: unchanged
        settle();
    endtask

    // extract: full-byte gather, ignored push, nothing after the payload
    task automatic test_extract_basic();
        write_reg(REG_MODE, CFG_W'(MODE_EXTRACT));
        write_reg(REG_BITS_PER_BYTE, 24'd8);
        write_reg(REG_PAYLOAD_BYTES, 24'd2);
        send_beat(KIND_COVER, 8'hFF);
        send_beat(KIND_PAYLOAD, 8'h12);
        send_beat(KIND_COVER, 8'h00);
        send_beat(KIND_COVER, 8'h5A);
        settle();
    endtask

    // bits_per_byte 0 acts as 1, 15 acts as 8
    task automatic test_bpb_clamp();
        write_reg(REG_MODE, CFG_W'(MODE_EMBED));
        write_reg(REG_BITS_PER_BYTE, 24'd0);
        write_reg(REG_PAYLOAD_BYTES, 24'd1);
        send_beat(KIND_PAYLOAD, 8'hA5);
        send_beat(KIND_COVER, 8'h00);
        send_beat(KIND_COVER, 8'hFF);
        settle();
        write_reg(REG_MODE, CFG_W'(MODE_EXTRACT));
        write_reg(REG_BITS_PER_BYTE, 24'd15);
        send_beat(KIND_COVER, 8'hC3);
        settle();
    endtask

    // length rewrite keeps the stream; done stays set once set
    task automatic test_length_change();
        write_reg(REG_MODE, CFG_W'(MODE_EMBED));
        write_reg(REG_BITS_PER_BYTE, 24'd4);
        send_beat(KIND_PAYLOAD, 8'h96);
        send_beat(KIND_COVER, 8'h00);
        settle();
        write_reg(REG_PAYLOAD_BYTES, 24'd0);
        send_beat(KIND_COVER, 8'h00);
        settle();
        write_reg(REG_PAYLOAD_BYTES, 24'd2);
        send_beat(KIND_COVER, 8'hF0);
        settle();
    endtask

    // max length, 8 bits per byte
    task automatic test_max_length();
        write_reg(REG_MODE, CFG_W'(MODE_EMBED));
        write_reg(REG_BITS_PER_BYTE, 24'd8);
        write_reg(REG_PAYLOAD_BYTES, 24'hFFFFFF);
        send_beat(KIND_PAYLOAD, 8'hFF);
        send_beat(KIND_COVER, 8'h00);
        settle();
    endtask

    // random stream settings; mostly short payloads so streams finish
    task automatic pick_stream_cfg(input mode_t m);
        int r;
        write_reg(REG_MODE, CFG_W'(m));
        r = $urandom_range(0, 99);
        write_reg(REG_BITS_PER_BYTE,
                  (r < 12) ? CFG_W'($urandom_range(0, 15)) : CFG_W'($urandom_range(1, 8)));
        r = $urandom_range(0, 99);
        if (r < 10)
            write_reg(REG_PAYLOAD_BYTES, 24'd0);
        else if (r < 16)
            write_reg(REG_PAYLOAD_BYTES, CFG_W'($urandom_range(0, 24'hFFFFFF)));
        else
            write_reg(REG_PAYLOAD_BYTES, CFG_W'($urandom_range(1, 6)));
    endtask

    // embed: keep the buffer fed so covers mostly carry bits; some noise
    task automatic test_random_embed(input int target);
        int sent;
        int r;
        sent = 0;
        steady = 1'b1;                        // opening stretch with no idling
        while (sent < target) begin
            pick_stream_cfg(MODE_EMBED);
            repeat ($urandom_range(20, 60)) begin
                if (sent >= 300)
                    steady = 1'b0;
                r = $urandom_range(0, 99);
                if (r < 10)
                    send_beat(kind_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                else if (!all_done() && pend_cnt < step_bits() && r < 90)
                    send_beat(KIND_PAYLOAD, 8'($urandom_range(0, 255)));
                else if (pend_cnt < 4'd8 && r < 35)
                    send_beat(KIND_PAYLOAD, 8'($urandom_range(0, 255)));
                else
                    send_beat(KIND_COVER, 8'($urandom_range(0, 255)));
                sent++;
                // sender holds off now and then until all results are in
                if ($urandom_range(0, 49) == 0)
                    settle();
            end
            settle();
        end
        steady = 1'b0;
    endtask

    // extract: stego bytes with the odd ignored push mixed in
    task automatic test_random_extract(input int target);
        int sent;
        sent = 0;
        while (sent < target) begin
            pick_stream_cfg(MODE_EXTRACT);
            repeat ($urandom_range(20, 60)) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_beat(KIND_PAYLOAD, 8'($urandom_range(0, 255)));
                end else begin
                    send_beat(KIND_COVER, 8'($urandom_range(0, 255)));
                end
                sent++;
            end
            settle();
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_embed_basic();
        test_extract_basic();
        test_bpb_clamp();
        test_length_change();
        test_max_length();
        test_random_embed(900);
        test_random_extract(850);

        settle();
        repeat (10) @(posedge aclk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog: a few thousand beats need far less than this
    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
